// File: design/mlfq_process_scheduler_macros.svh
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_macros
// Assertion helpers for the scheduler.
// ----------------------------------------------------------------------------
`ifndef MLFQ_PROCESS_SCHEDULER_MACROS_SVH
`define MLFQ_PROCESS_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MLFQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the four-level feedback scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam logic [15:0] BOOST_PERIOD_RST = 16'd100;
  localparam logic [15:0] STARVE_LIMIT_RST = 16'd100;
  localparam logic [4:0]  SLICE0_RST       = 5'd5;
  localparam logic [4:0]  SLICE1_RST       = 5'd5;
  localparam logic [4:0]  SLICE2_RST       = 5'd10;
  localparam logic [4:0]  SLICE3_RST       = 5'd20;
  localparam logic [1:0]  TOP_LEVEL        = 2'd3;

  typedef enum logic [2:0] {
    CMD_ALLOC    = 3'd0,
    CMD_RUNNABLE = 3'd1,
    CMD_BLOCK    = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_PICK     = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    REG_BOOST_PERIOD = 3'd0,
    REG_STARVE_LIMIT = 3'd1,
    REG_SLICE0       = 3'd2,
    REG_SLICE1       = 3'd3,
    REG_SLICE2       = 3'd4,
    REG_SLICE3       = 3'd5
  } reg_e;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] slot;
    logic [1:0] level;
  } mlfq_req_t;

  typedef struct packed {
    logic        chosen_valid;
    logic [5:0]  chosen_slot;
    logic        preempted;
    logic [1:0]  level_out;
    logic [31:0] ticks_out;
  } mlfq_rsp_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  level;
    logic [4:0]  slice_used;
    logic [15:0] wait_cnt;
  } slot_row_t;

  typedef logic [3:0][31:0] tick_row_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_PREP,
    OP_SWEEP,
    OP_ROW_RD,
    OP_ROW_WR,
    OP_ACCT_RD,
    OP_ACCT_WR
  } dp_op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic       slot_ok;
    logic       run_active;
    logic       sweep_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/mlfq_datapath.sv
// ----------------------------------------------------------------------------
// mlfq_datapath
// Slot tables, scan engine, tick accounting and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlfq_datapath import mlfq_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_op_e     op,
  output dp_status_t      status,
  input  wire mlfq_req_t  req,
  output mlfq_rsp_t       rsp,
  input  wire logic       cfg_valid,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(4 * SLOT_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX   = IW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] TICK_TOTAL = CW'(SLOT_COUNT);
  localparam logic [CW-1:0] PICK_TOTAL = CW'(4 * SLOT_COUNT);

  // configuration
  logic [15:0]     boost_period;
  logic [15:0]     starve_limit;
  logic [3:0][4:0] slice_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_period <= BOOST_PERIOD_RST;
      starve_limit <= STARVE_LIMIT_RST;
      slice_cfg    <= {SLICE3_RST, SLICE2_RST, SLICE1_RST, SLICE0_RST};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOOST_PERIOD: boost_period <= cfg_data;
        REG_STARVE_LIMIT: starve_limit <= cfg_data;
        REG_SLICE0:       slice_cfg[0] <= cfg_data[4:0];
        REG_SLICE1:       slice_cfg[1] <= cfg_data[4:0];
        REG_SLICE2:       slice_cfg[2] <= cfg_data[4:0];
        REG_SLICE3:       slice_cfg[3] <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // latched command
  mlfq_req_t cmd_q;
  logic [IW-1:0] slot_idx;
  logic slot_ok;
  assign slot_idx = IW'(cmd_q.slot);
  assign slot_ok  = (32'(cmd_q.slot) < 32'(SLOT_COUNT));

  // tables; both rows of a slot are always written together, so one
  // valid bit per slot marks them live
  slot_row_t slot_mem [SLOT_COUNT];
  tick_row_t tick_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld;
  slot_row_t slot_q;
  tick_row_t tick_q;
  logic slot_vq;
  slot_row_t row;
  tick_row_t trow;

  logic [IW-1:0] rd_addr;
  logic          slot_we, tick_we, vld_clr;
  logic [IW-1:0] wa;
  slot_row_t     slot_wd;
  tick_row_t     tick_wd;

  // scheduler state
  logic          run_active;
  logic [IW-1:0] run_idx;
  logic [1:0]    scan_pass;
  logic [IW-1:0] scan_index;
  logic [15:0]   boost_cnt;
  logic          boost_flag;

  // sweep engine
  logic [IW-1:0] sw_addr;
  logic [1:0]    sw_pass;
  logic [CW-1:0] sw_cnt;
  logic          ev_vld;
  logic [IW-1:0] ev_idx;
  logic [1:0]    ev_pass;
  logic          hit;
  logic          is_tick;
  logic [CW-1:0] total;
  logic          issue, evaluate, pick_ok;
  logic [IW-1:0] next_idx;
  logic [1:0]    next_pass;

  mlfq_rsp_t res;

  // per-step evaluation values
  logic [15:0] wait_inc;
  slot_row_t   aged_row;
  logic [1:0]  acct_lv;
  logic [4:0]  su_next;
  logic        expire;
  slot_row_t   acct_row;
  tick_row_t   acct_trow;
  logic [15:0] boost_cnt_inc;

  assign row  = slot_vq ? slot_q : '0;
  assign trow = slot_vq ? tick_q : '0;

  assign is_tick   = (cmd_q.cmd == CMD_TICK);
  assign total     = is_tick ? TICK_TOTAL : PICK_TOTAL;
  assign issue     = (op == OP_SWEEP) && (sw_cnt != total) && !hit;
  assign evaluate  = (op == OP_SWEEP) && ev_vld && !hit;
  assign pick_ok   = (row.status == ST_READY) && (row.level <= ev_pass);
  assign next_idx  = (ev_idx == LAST_IDX) ? '0 : ev_idx + 1'b1;
  assign next_pass = (ev_idx == LAST_IDX) ? ev_pass + 2'd1 : ev_pass;
  assign boost_cnt_inc = boost_cnt + 16'd1;

  always_comb begin
    wait_inc = (row.wait_cnt == 16'hFFFF) ? row.wait_cnt : row.wait_cnt + 16'd1;
    aged_row = row;
    if (row.status == ST_READY) begin
      aged_row.wait_cnt = wait_inc;
      if (boost_flag && (wait_inc >= starve_limit)) begin
        aged_row.wait_cnt   = '0;
        aged_row.slice_used = '0;
        if (row.level != 2'd0) aged_row.level = row.level - 2'd1;
      end
    end

    acct_lv   = row.level;
    su_next   = row.slice_used + 5'd1;
    expire    = (su_next >= slice_cfg[acct_lv]);
    acct_trow = trow;
    if (trow[acct_lv] != 32'hFFFF_FFFF) acct_trow[acct_lv] = trow[acct_lv] + 32'd1;
    acct_row            = row;
    acct_row.wait_cnt   = '0;
    acct_row.slice_used = su_next;
    if (expire) begin
      acct_row.status     = ST_READY;
      acct_row.slice_used = '0;
      if (acct_lv != TOP_LEVEL) acct_row.level = acct_lv + 2'd1;
    end
  end

  // table access control
  always_comb begin
    rd_addr = sw_addr;
    slot_we = 1'b0;
    vld_clr = 1'b0;
    wa      = slot_idx;
    slot_wd = row;
    tick_wd = trow;
    case (op)
      OP_ROW_RD:  rd_addr = slot_idx;
      OP_ACCT_RD: rd_addr = run_idx;
      OP_ROW_WR: begin
        case (cmd_q.cmd)
          CMD_ALLOC: vld_clr = 1'b1;
          CMD_RUNNABLE: begin
            slot_we        = (row.status != ST_RUN);
            slot_wd.status = ST_READY;
          end
          CMD_BLOCK: begin
            slot_we        = 1'b1;
            slot_wd.status = ST_IDLE;
          end
          default: ;
        endcase
      end
      OP_SWEEP: begin
        wa = ev_idx;
        if (evaluate) begin
          if (is_tick) begin
            slot_we = (row.status == ST_READY);
            slot_wd = aged_row;
          end else begin
            slot_we        = pick_ok;
            slot_wd.status = ST_RUN;
          end
        end
      end
      OP_ACCT_WR: begin
        wa      = run_idx;
        slot_we = 1'b1;
        slot_wd = acct_row;
        tick_wd = acct_trow;
      end
      default: ;
    endcase
    tick_we = slot_we;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[wa] <= slot_wd;
    if (tick_we) tick_mem[wa] <= tick_wd;
    slot_q  <= slot_mem[rd_addr];
    tick_q  <= tick_mem[rd_addr];
    slot_vq <= slot_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else begin
      if (slot_we) slot_vld[wa] <= 1'b1;
      if (vld_clr) slot_vld[wa] <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_idx    <= '0;
      scan_pass  <= '0;
      scan_index <= '0;
      boost_cnt  <= '0;
      boost_flag <= 1'b0;
      ev_vld     <= 1'b0;
      hit        <= 1'b0;
      sw_cnt     <= '0;
    end else begin
      case (op)
        OP_PREP: begin
          sw_cnt <= '0;
          ev_vld <= 1'b0;
          hit    <= 1'b0;
          if (is_tick) begin
            if (boost_cnt_inc >= boost_period) begin
              boost_cnt  <= '0;
              boost_flag <= 1'b1;
            end else begin
              boost_cnt  <= boost_cnt_inc;
              boost_flag <= 1'b0;
            end
          end
        end
        OP_SWEEP: begin
          ev_vld <= issue;
          if (issue) sw_cnt <= sw_cnt + 1'b1;
          if (evaluate && !is_tick && pick_ok) begin
            hit        <= 1'b1;
            run_active <= 1'b1;
            run_idx    <= ev_idx;
            scan_index <= next_idx;
            scan_pass  <= next_pass;
          end
        end
        OP_ROW_WR: begin
          if ((cmd_q.cmd == CMD_ALLOC || cmd_q.cmd == CMD_BLOCK) && run_idx == slot_idx)
            run_active <= 1'b0;
        end
        OP_ACCT_WR: if (expire) run_active <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_q <= req;
        res   <= '0;
      end
      OP_PREP: begin
        sw_addr <= is_tick ? '0 : scan_index;
        sw_pass <= scan_pass;
      end
      OP_SWEEP: begin
        if (issue) begin
          sw_addr <= (sw_addr == LAST_IDX) ? '0 : sw_addr + 1'b1;
          if (sw_addr == LAST_IDX) sw_pass <= sw_pass + 2'd1;
        end
        ev_idx  <= sw_addr;
        ev_pass <= sw_pass;
        if (evaluate && !is_tick && pick_ok) begin
          res.chosen_valid <= 1'b1;
          res.chosen_slot  <= 6'(ev_idx);
          res.level_out    <= row.level;
        end
      end
      OP_ROW_WR: begin
        if (cmd_q.cmd == CMD_READ) begin
          res.level_out <= row.level;
          res.ticks_out <= trow[cmd_q.level];
        end
      end
      OP_ACCT_WR: begin
        res.preempted <= expire;
        res.level_out <= acct_row.level;
      end
      default: ;
    endcase
  end

  assign rsp    = res;
  assign status = '{cmd:        cmd_q.cmd,
                    slot_ok:    slot_ok,
                    run_active: run_active,
                    sweep_done: hit || ((sw_cnt == total) && !ev_vld)};

endmodule

`default_nettype wire

// File: design/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Command sequencer: steps the datapath through each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ctrl import mlfq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  output logic            done,
  output dp_op_e          op,
  input  wire dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ROW_RD, S_ROW_WR, S_PREP, S_SWEEP,
    S_ACCT_RD, S_ACCT_WR, S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_DECODE;
        S_DECODE: begin
          case (status.cmd)
            CMD_ALLOC, CMD_RUNNABLE, CMD_BLOCK, CMD_READ:
              state <= status.slot_ok ? S_ROW_RD : S_FINISH;
            CMD_TICK: state <= S_PREP;
            CMD_PICK: state <= status.run_active ? S_FINISH : S_PREP;
            default:  state <= S_FINISH;
          endcase
        end
        S_ROW_RD: state <= S_ROW_WR;
        S_ROW_WR: state <= S_FINISH;
        S_PREP:   state <= S_SWEEP;
        S_SWEEP: begin
          if (status.sweep_done) begin
            if (status.cmd == CMD_TICK && status.run_active) state <= S_ACCT_RD;
            else state <= S_FINISH;
          end
        end
        S_ACCT_RD: state <= S_ACCT_WR;
        S_ACCT_WR: state <= S_FINISH;
        S_FINISH:  state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);

  always_comb begin
    unique case (state)
      S_IDLE:    op = start ? OP_LOAD : OP_IDLE;
      S_ROW_RD:  op = OP_ROW_RD;
      S_ROW_WR:  op = OP_ROW_WR;
      S_PREP:    op = OP_PREP;
      S_SWEEP:   op = OP_SWEEP;
      S_ACCT_RD: op = OP_ACCT_RD;
      S_ACCT_WR: op = OP_ACCT_WR;
      default:   op = OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/mlfq_process_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler
// Four-level feedback scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Sequence: allocate/runnable/block/read read and then write the slot row; bad slot,
//   unknown code or pick while running go straight to finish; tick sweeps the table
//   once, then accounts the running task if there is one; pick sweeps up to four passes.
// Throughput: one command at a time; the slot-table sweep, one slot per cycle
//   through the table's single read port, sets the tick and pick times.
// Reset: synchronous; all slots idle at level 0, counts zero, no task running.
// The result beat is a one-cycle strobe on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

`include "mlfq_process_scheduler_macros.svh"

module mlfq_process_scheduler import mlfq_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command beat
  input  wire logic        start,
  output logic             busy,
  input  wire mlfq_req_t   req,
  // result beat
  output logic             done,
  output mlfq_rsp_t        rsp,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_op_e     op;
  dp_status_t status;

  // Registers are always writable; the user must write them only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  mlfq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .op     (op),
    .status (status)
  );

  mlfq_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .req       (req),
    .rsp       (rsp),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result strobe always comes while the command is still outstanding
  `MLFQ_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "done outside a command")
  // an accepted command is taken up at once
  `MLFQ_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "command not taken")
  // one result per command
  `MLFQ_ASSERT_NEXT(a_done_once, clk, rst, done, !busy && !done, "result repeated")
  // a pick never also reports a preemption
  `MLFQ_ASSERT_NOW(a_pick_tick, clk, rst, done && rsp.chosen_valid, !rsp.preempted, "mixed result")

endmodule

`default_nettype wire
